FILE: sv/msbp_pkg.sv
// Shared constants and types for the MSB-first bit packer.
`timescale 1ns / 1ps
package msbp_pkg;
   localparam int WORD_WIDTH = 32;
   localparam int WORD_BYTES = WORD_WIDTH / 8;
   localparam int HELD_WIDTH = $clog2(WORD_WIDTH);
   localparam int LEN_WIDTH = 6;
   localparam int BYTE_CNT_WIDTH = 16;
   localparam int WORDS_WIDTH = 14;
   localparam int WB_WIDTH = 3;
   localparam int CSR_ADDR_WIDTH = 2;

   localparam logic FUNC_PUT = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_OUTPUT_LIMIT = 2'd0;
   localparam logic [BYTE_CNT_WIDTH-1:0] LIMIT_RESET = 16'hFFFF;

   typedef struct packed {
      logic [WORD_WIDTH-1:0]     packed_word;
      logic [WB_WIDTH-1:0]       word_bytes;
      logic [BYTE_CNT_WIDTH-1:0] total_bytes;
      logic                      is_final;
      logic                      overflow;
   } rsp_type;
endpackage

FILE: sv/msbp_core.sv
// Packing datapath: accumulator, bit count, word count and result formation.
`timescale 1ns / 1ps
module msbp_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              func,
   input  logic [msbp_pkg::WORD_WIDTH-1:0]   field_value,
   input  logic [msbp_pkg::LEN_WIDTH-1:0]    field_length,
   input  logic [msbp_pkg::BYTE_CNT_WIDTH-1:0] limit,
   output logic                              res_valid,
   output msbp_pkg::rsp_type                 res
);
   import msbp_pkg::*;

   logic [WORD_WIDTH-1:0]  acc_ff, acc_in;
   logic [HELD_WIDTH-1:0]  held_ff, held_in;
   logic [WORDS_WIDTH-1:0] words_ff, words_in;

   logic [LEN_WIDTH-1:0]      len_sat;
   logic [WORD_WIDTH-1:0]     value_masked;
   logic [LEN_WIDTH-1:0]      filled;
   logic [LEN_WIDTH-1:0]      shift_amt;
   logic [2*WORD_WIDTH-1:0]   shifted;
   logic [2*WORD_WIDTH-1:0]   combined;
   logic                      full;
   logic                      put_active;
   logic [BYTE_CNT_WIDTH-1:0] used;
   logic [WB_WIDTH-1:0]       part_bytes;
   logic [BYTE_CNT_WIDTH:0]   total_part;
   logic [BYTE_CNT_WIDTH:0]   total_full;
   logic                      fits_part;
   logic                      fits_full;

   always_comb begin
      if (field_length > LEN_WIDTH'(WORD_WIDTH)) begin
         len_sat = LEN_WIDTH'(WORD_WIDTH);
      end else begin
         len_sat = field_length;
      end
      value_masked = field_value & ({WORD_WIDTH{1'b1}} >> (LEN_WIDTH'(WORD_WIDTH) - len_sat));
      filled = LEN_WIDTH'(held_ff) + len_sat;
      // place the field just below the bits already held in a double-width window
      shift_amt = LEN_WIDTH'((LEN_WIDTH + 1)'(2 * WORD_WIDTH) - (LEN_WIDTH + 1)'(filled));
      shifted = {{WORD_WIDTH{1'b0}}, value_masked} << shift_amt;
      combined = {acc_ff, {WORD_WIDTH{1'b0}}} | shifted;
      full = filled >= LEN_WIDTH'(WORD_WIDTH);
      put_active = accept && (func == FUNC_PUT) && (field_length != '0);

      used = {words_ff, 2'b00};
      part_bytes = WB_WIDTH'((LEN_WIDTH'(held_ff) + LEN_WIDTH'(7)) >> 3);
      total_part = {1'b0, used} + (BYTE_CNT_WIDTH + 1)'(part_bytes);
      total_full = {1'b0, used} + (BYTE_CNT_WIDTH + 1)'(WORD_BYTES);
      fits_part = total_part <= {1'b0, limit};
      fits_full = total_full <= {1'b0, limit};

      acc_in = acc_ff;
      held_in = held_ff;
      words_in = words_ff;
      res_valid = 1'b0;
      res = '0;

      if (accept && func == FUNC_FLUSH) begin
         res_valid = 1'b1;
         res.is_final = 1'b1;
         res.total_bytes = used;
         if (part_bytes != '0) begin
            if (fits_part) begin
               res.packed_word = acc_ff;
               res.word_bytes = part_bytes;
               res.total_bytes = total_part[BYTE_CNT_WIDTH-1:0];
            end else begin
               res.overflow = 1'b1;
            end
         end
         acc_in = '0;
         held_in = '0;
         words_in = '0;
      end else if (put_active) begin
         // tail bits past the word boundary equal the low bits of filled
         held_in = filled[HELD_WIDTH-1:0];
         if (full) begin
            acc_in = combined[WORD_WIDTH-1:0];
            res_valid = 1'b1;
            if (fits_full) begin
               res.packed_word = combined[2*WORD_WIDTH-1:WORD_WIDTH];
               res.word_bytes = WB_WIDTH'(WORD_BYTES);
               words_in = words_ff + 1'b1;
            end else begin
               res.overflow = 1'b1;
            end
         end else begin
            acc_in = combined[2*WORD_WIDTH-1:WORD_WIDTH];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         held_ff <= '0;
         words_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         held_ff <= held_in;
         words_ff <= words_in;
      end
   end
endmodule

FILE: sv/msbp_out_buf.sv
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps
module msbp_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  msbp_pkg::rsp_type in_data,
   output logic              busy,
   output logic              out_valid,
   output msbp_pkg::rsp_type out_data,
   input  logic              out_stall
);
   import msbp_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    take;

   always_comb begin
      take = main_valid_ff && !out_stall;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in = main_ff;
      skid_in = skid_ff;
      if (skid_valid_ff) begin
         // input is held off while the skid entry is occupied
         if (take) begin
            main_in = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff || take) begin
            main_in = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign busy = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data = main_ff;
endmodule

FILE: sv/msb_first_bit_packer.sv
// Top level of the MSB-first bit packer: channels, register port, submodules.
// Usage:
//  - req channel: func selects put (append field_length low bits of field_value
//    after those held) or flush (emit the partial word, report total bytes).
//  - rsp channel: one result per transaction that fills a word, and one per flush;
//    a put that fills no word gives no result.
//  - csr port: APB-style, register output_limit_bytes at byte address 0.
//  - Output: each result is registered in the output buffer before it appears on rsp.
//  - Throughput: one req transaction per cycle while req_stall is low; the accumulator update is a
//    single shift and OR over a 64-bit window plus one compare against the limit.
//  - A word that would exceed output_limit_bytes is dropped, flagged by overflow.
//  - Reset: accumulator and counters clear, limit returns to 65535, rsp empties.
//  - Stall: a result waits in the output register while rsp_stall is high; one
//    more result can be absorbed in a skid register, after which req_stall rises
//    until the receiver takes a result.
`timescale 1ns / 1ps
module msb_first_bit_packer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic [msbp_pkg::WORD_WIDTH-1:0]      req_field_value,
   input  logic [msbp_pkg::LEN_WIDTH-1:0]       req_field_length,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [msbp_pkg::WORD_WIDTH-1:0]      rsp_packed_word,
   output logic [msbp_pkg::WB_WIDTH-1:0]        rsp_word_bytes,
   output logic [msbp_pkg::BYTE_CNT_WIDTH-1:0]  rsp_total_bytes,
   output logic                                 rsp_is_final,
   output logic                                 rsp_overflow,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [msbp_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import msbp_pkg::*;

   logic [BYTE_CNT_WIDTH-1:0] limit_ff, limit_in;
   logic    accept;
   logic    res_valid;
   rsp_type res;
   rsp_type out_data;
   logic    busy;

   assign csr_pready = 1'b1;

   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_OUTPUT_LIMIT) begin
         limit_in = csr_pwdata[BYTE_CNT_WIDTH-1:0];
      end
      if (csr_paddr == CSR_OUTPUT_LIMIT) begin
         csr_prdata = {{(32 - BYTE_CNT_WIDTH){1'b0}}, limit_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign req_stall = busy;
   assign accept = req_valid && !busy;

   msbp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .func         (req_func),
      .field_value  (req_field_value),
      .field_length (req_field_length),
      .limit        (limit_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   msbp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .busy      (busy),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_stall (rsp_stall)
   );

   assign rsp_packed_word = out_data.packed_word;
   assign rsp_word_bytes = out_data.word_bytes;
   assign rsp_total_bytes = out_data.total_bytes;
   assign rsp_is_final = out_data.is_final;
   assign rsp_overflow = out_data.overflow;
endmodule
